// File: src/median_filter_3x3_top_macros.svh
// ----------------------------------------------------------------------------
// median_filter_3x3_top_macros.svh
// Assertion macros for the 3x3 median filter. They compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_FILTER_3X3_TOP_MACROS_SVH
`define MEDIAN_FILTER_3X3_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define MF3_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("median filter assertion failed");

// Next-cycle implication
`define MF3_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("median filter assertion failed");

`else

`define MF3_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MF3_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: src/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared constants, codes and types of the 3x3 median filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

    // Default sizing
    localparam int MF3_MAX_WIDTH  = 2048;
    localparam int MF3_PIXEL_BITS = 8;

    // Fixed field widths
    localparam int PIX_W        = 8;
    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 13;
    localparam int ROW_W        = 12;
    localparam int CMP_W        = 16;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    // Frame size limits and reset values
    localparam int HEIGHT_LIMIT = 4096;
    localparam int MIN_DIM      = 3;
    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd512;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd512;

    // Operation codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Register indexes (paddr[2])
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Per-transaction control decided at acceptance
    typedef struct packed {
        logic flush;
        logic full;
        logic interior;
        logic last;
        logic produce;
    } mf3_item_t;

endpackage

// File: src/median_filter_3x3_top.sv
// ----------------------------------------------------------------------------
// median_filter_3x3_top
// Streaming 3x3 median filter over one 8-bit image channel.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while in_ready is high and answers each
// pixel frame_width+1 pixels later, at one result per clock while out_ready is
// high. A transaction passes the work stage after the line-memory read and is
// then loaded into the result register, which drives out_valid. The first
// frame_width+1 pixels after reset or a register write give no result; flush
// transactions drain pending pixels as passthrough. Interior pixels get the
// median of their nine neighbors, border rows and columns pass through. After
// reset the line memories are zeroed by a sweep over all MAX_WIDTH entries
// (2048 by default) during which in_ready stays low; register writes are taken.
// ----------------------------------------------------------------------------
`include "median_filter_3x3_top_macros.svh"

module median_filter_3x3_top
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH  = MF3_MAX_WIDTH,
    parameter int PIXEL_BITS = MF3_PIXEL_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  operation,
    input  logic [PIX_W-1:0]      pixel_in,
    // Output channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PIX_W-1:0]      pixel_out,
    output logic                  frame_end,
    // Register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic [WIDTH_REG_W-1:0]  frame_width;
    logic [HEIGHT_REG_W-1:0] frame_height;
    logic                    restart;
    logic                    in_accept;
    mf3_item_t               item;
    logic [COL_W-1:0]        in_col;
    logic [COL_W-1:0]        rd_addr;
    logic [PIXEL_BITS-1:0]   rd_upper;
    logic [PIXEL_BITS-1:0]   rd_middle;
    logic                    wr_en;
    logic [COL_W-1:0]        wr_addr;
    logic [PIXEL_BITS-1:0]   wr_upper;
    logic [PIXEL_BITS-1:0]   wr_middle;
    logic                    clearing;
    logic                    stage_free;
    logic                    stage_busy;

    // Input handshake
    assign in_ready  = !clearing && stage_free;
    assign in_accept = in_valid && in_ready;

    mf3_cfg #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .frame_width  (frame_width),
        .frame_height (frame_height),
        .restart      (restart)
    );

    mf3_seq #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .restart      (restart),
        .accept       (in_accept),
        .operation    (operation),
        .frame_width  (frame_width),
        .frame_height (frame_height),
        .item         (item),
        .in_col       (in_col),
        .rd_addr      (rd_addr)
    );

    mf3_linebuf #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_linebuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (in_accept),
        .rd_addr   (rd_addr),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_upper  (wr_upper),
        .wr_middle (wr_middle),
        .rd_upper  (rd_upper),
        .rd_middle (rd_middle),
        .clearing  (clearing)
    );

    mf3_pipe #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (restart),
        .accept     (in_accept),
        .item       (item),
        .px_in      (PIXEL_BITS'(pixel_in)),
        .col_in     (in_col),
        .rd_addr    (rd_addr),
        .rd_upper   (rd_upper),
        .rd_middle  (rd_middle),
        .out_ready  (out_ready),
        .stage_free (stage_free),
        .stage_busy (stage_busy),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_upper   (wr_upper),
        .wr_middle  (wr_middle),
        .out_valid  (out_valid),
        .pixel_out  (pixel_out),
        .frame_end  (frame_end)
    );

    // No transaction enters while the line memories are being zeroed
    `MF3_ASSERT_IMP(a_no_accept_in_sweep, clk, rst_n, clearing, !in_ready)
    // A new result only comes out of an occupied work stage
    `MF3_ASSERT_IMP(a_result_from_stage, clk, rst_n, $rose(out_valid), $past(stage_busy))
    // The memory sweep runs once after reset and never restarts
    `MF3_ASSERT_NXT(a_sweep_once, clk, rst_n, !clearing, !clearing)

endmodule

// File: src/mf3_cfg.sv
// ----------------------------------------------------------------------------
// mf3_cfg
// APB register file: frame width and height with saturation on write.
// ----------------------------------------------------------------------------
module mf3_cfg
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH = MF3_MAX_WIDTH
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready,
    output logic [WIDTH_REG_W-1:0]  frame_width,
    output logic [HEIGHT_REG_W-1:0] frame_height,
    output logic                    restart
);

    logic [WIDTH_REG_W-1:0]  frame_width_reg;
    logic [WIDTH_REG_W-1:0]  frame_width_next;
    logic [HEIGHT_REG_W-1:0] frame_height_reg;
    logic [HEIGHT_REG_W-1:0] frame_height_next;
    logic [WIDTH_REG_W-1:0]  width_sat;
    logic [HEIGHT_REG_W-1:0] height_sat;
    logic                    wr_strobe;
    logic                    reg_sel;

    assign pready    = 1'b1;
    assign wr_strobe = psel && penable && pwrite;
    assign reg_sel   = paddr[2];
    assign restart   = wr_strobe;

    // Clamp written values into the legal range
    always_comb
    begin
        width_sat = pwdata[WIDTH_REG_W-1:0];
        if (width_sat < WIDTH_REG_W'(MIN_DIM))
            width_sat = WIDTH_REG_W'(MIN_DIM);
        else if (32'(width_sat) > MAX_WIDTH)
            width_sat = WIDTH_REG_W'(MAX_WIDTH);

        height_sat = pwdata[HEIGHT_REG_W-1:0];
        if (height_sat < HEIGHT_REG_W'(MIN_DIM))
            height_sat = HEIGHT_REG_W'(MIN_DIM);
        else if (height_sat > HEIGHT_REG_W'(HEIGHT_LIMIT))
            height_sat = HEIGHT_REG_W'(HEIGHT_LIMIT);
    end

    // Register write decode
    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        if (wr_strobe)
        begin
            case (reg_sel)
                REG_FRAME_WIDTH:  frame_width_next  = width_sat;
                REG_FRAME_HEIGHT: frame_height_next = height_sat;
                default:          frame_width_next  = frame_width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
        end
    end

    // Read mux
    always_comb
    begin
        case (reg_sel)
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height_reg);
            default:          prdata = '0;
        endcase
    end

    assign frame_width  = frame_width_reg;
    assign frame_height = frame_height_reg;

endmodule

// File: src/mf3_seq.sv
// ----------------------------------------------------------------------------
// mf3_seq
// Raster position tracking for input and output, pending count, and the
// per-transaction decisions (full window, interior, frame end).
// ----------------------------------------------------------------------------
module mf3_seq
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH = MF3_MAX_WIDTH,
    localparam int COL_W    = $clog2(MAX_WIDTH)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    restart,
    input  logic                    accept,
    input  logic                    operation,
    input  logic [WIDTH_REG_W-1:0]  frame_width,
    input  logic [HEIGHT_REG_W-1:0] frame_height,
    output mf3_item_t               item,
    output logic [COL_W-1:0]        in_col,
    output logic [COL_W-1:0]        rd_addr
);

    localparam int PEND_W = $clog2(MAX_WIDTH + 2);

    logic [COL_W-1:0]  in_col_reg,  in_col_next;
    logic [ROW_W-1:0]  in_row_reg,  in_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;
    logic [PEND_W-1:0] pending_reg, pending_next;

    logic [CMP_W-1:0]  w16;
    logic [CMP_W-1:0]  h16;
    logic [CMP_W-1:0]  in_col_inc;
    logic [CMP_W-1:0]  in_row_inc;
    logic [CMP_W-1:0]  out_col_inc;
    logic [CMP_W-1:0]  out_row_inc;
    logic [COL_W-1:0]  in_col_adv,  out_col_adv;
    logic [ROW_W-1:0]  in_row_adv,  out_row_adv;

    assign w16 = CMP_W'(frame_width);
    assign h16 = CMP_W'(frame_height);

    // Next raster positions (column wraps into row, row wraps into frame)
    always_comb
    begin
        in_col_inc  = CMP_W'(in_col_reg) + CMP_W'(1);
        in_row_inc  = CMP_W'(in_row_reg) + CMP_W'(1);
        out_col_inc = CMP_W'(out_col_reg) + CMP_W'(1);
        out_row_inc = CMP_W'(out_row_reg) + CMP_W'(1);

        in_col_adv = COL_W'(in_col_inc);
        in_row_adv = in_row_reg;
        if (in_col_inc >= w16)
        begin
            in_col_adv = '0;
            in_row_adv = (in_row_inc >= h16) ? '0 : ROW_W'(in_row_inc);
        end

        out_col_adv = COL_W'(out_col_inc);
        out_row_adv = out_row_reg;
        if (out_col_inc >= w16)
        begin
            out_col_adv = '0;
            out_row_adv = (out_row_inc >= h16) ? '0 : ROW_W'(out_row_inc);
        end
    end

    // Decisions for the transaction at the input
    always_comb
    begin
        item.flush    = (operation == OP_FLUSH);
        item.full     = (CMP_W'(pending_reg) == w16 + CMP_W'(1));
        item.interior = (out_row_reg != '0) &&
                        (CMP_W'(out_row_reg) + CMP_W'(2) <= h16) &&
                        (out_col_reg != '0) &&
                        (CMP_W'(out_col_reg) + CMP_W'(2) <= w16);
        item.last     = (CMP_W'(out_row_reg) == h16 - CMP_W'(1)) &&
                        (CMP_W'(out_col_reg) == w16 - CMP_W'(1));
        item.produce  = item.flush ? (pending_reg != '0) : item.full;
    end

    // Counter updates
    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        pending_next = pending_reg;
        if (restart)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            pending_next = '0;
        end
        else if (accept)
        begin
            if (!item.flush)
            begin
                in_col_next = in_col_adv;
                in_row_next = in_row_adv;
                if (item.full)
                begin
                    out_col_next = out_col_adv;
                    out_row_next = out_row_adv;
                end
                else
                begin
                    pending_next = pending_reg + PEND_W'(1);
                end
            end
            else if (item.produce)
            begin
                out_col_next = out_col_adv;
                out_row_next = out_row_adv;
                pending_next = pending_reg - PEND_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            pending_reg <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            pending_reg <= pending_next;
        end
    end

    assign in_col  = in_col_reg;
    assign rd_addr = item.flush ? out_col_reg : in_col_reg;

endmodule

// File: src/mf3_linebuf.sv
// ----------------------------------------------------------------------------
// mf3_linebuf
// Upper and middle line memories with registered read and a zeroing sweep
// after reset.
// ----------------------------------------------------------------------------
module mf3_linebuf
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH  = MF3_MAX_WIDTH,
    parameter int PIXEL_BITS = MF3_PIXEL_BITS,
    localparam int COL_W     = $clog2(MAX_WIDTH)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rd_en,
    input  logic [COL_W-1:0]      rd_addr,
    input  logic                  wr_en,
    input  logic [COL_W-1:0]      wr_addr,
    input  logic [PIXEL_BITS-1:0] wr_upper,
    input  logic [PIXEL_BITS-1:0] wr_middle,
    output logic [PIXEL_BITS-1:0] rd_upper,
    output logic [PIXEL_BITS-1:0] rd_middle,
    output logic                  clearing
);

    logic [PIXEL_BITS-1:0] upper_mem  [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] middle_mem [MAX_WIDTH];

    logic [PIXEL_BITS-1:0] rd_upper_reg;
    logic [PIXEL_BITS-1:0] rd_middle_reg;
    logic                  clearing_reg, clearing_next;
    logic [COL_W-1:0]      clr_addr_reg, clr_addr_next;

    logic                  mem_we;
    logic [COL_W-1:0]      mem_addr;
    logic [PIXEL_BITS-1:0] mem_upper;
    logic [PIXEL_BITS-1:0] mem_middle;

    // Write port: sweep has priority (no transactions run during it)
    always_comb
    begin
        mem_we     = clearing_reg || wr_en;
        mem_addr   = clearing_reg ? clr_addr_reg : wr_addr;
        mem_upper  = clearing_reg ? '0 : wr_upper;
        mem_middle = clearing_reg ? '0 : wr_middle;
    end

    // Sweep control
    always_comb
    begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            if (clr_addr_reg == COL_W'(MAX_WIDTH - 1))
                clearing_next = 1'b0;
            else
                clr_addr_next = clr_addr_reg + COL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // Memories
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            upper_mem[mem_addr]  <= mem_upper;
            middle_mem[mem_addr] <= mem_middle;
        end
        if (rd_en)
        begin
            rd_upper_reg  <= upper_mem[rd_addr];
            rd_middle_reg <= middle_mem[rd_addr];
        end
    end

    assign rd_upper  = rd_upper_reg;
    assign rd_middle = rd_middle_reg;
    assign clearing  = clearing_reg;

endmodule

// File: src/mf3_median9.sv
// ----------------------------------------------------------------------------
// mf3_median9
// Median of nine values: sort three triples, then take the median of the
// largest minimum, the middle median and the smallest maximum.
// ----------------------------------------------------------------------------
module mf3_median9
    import mf3_pkg::*;
#(
    parameter int PIXEL_BITS = MF3_PIXEL_BITS
)
(
    input  logic [8:0][PIXEL_BITS-1:0] taps,
    output logic [PIXEL_BITS-1:0]      median
);

    logic [2:0][PIXEL_BITS-1:0] lo;
    logic [2:0][PIXEL_BITS-1:0] mi;
    logic [2:0][PIXEL_BITS-1:0] hi;

    function automatic logic [PIXEL_BITS-1:0] min2(
        input logic [PIXEL_BITS-1:0] a,
        input logic [PIXEL_BITS-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

    function automatic logic [PIXEL_BITS-1:0] max2(
        input logic [PIXEL_BITS-1:0] a,
        input logic [PIXEL_BITS-1:0] b
    );
        return (a < b) ? b : a;
    endfunction

    function automatic logic [PIXEL_BITS-1:0] med3(
        input logic [PIXEL_BITS-1:0] a,
        input logic [PIXEL_BITS-1:0] b,
        input logic [PIXEL_BITS-1:0] c
    );
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    // Per-triple min, median, max
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            lo[r] = min2(min2(taps[3*r], taps[3*r+1]), taps[3*r+2]);
            mi[r] = med3(taps[3*r], taps[3*r+1], taps[3*r+2]);
            hi[r] = max2(max2(taps[3*r], taps[3*r+1]), taps[3*r+2]);
        end
    end

    assign median = med3(max2(max2(lo[0], lo[1]), lo[2]),
                         med3(mi[0], mi[1], mi[2]),
                         min2(min2(hi[0], hi[1]), hi[2]));

endmodule

// File: src/mf3_pipe.sv
// ----------------------------------------------------------------------------
// mf3_pipe
// Work stage and result register: column window, median or passthrough
// selection, line write-back and read forwarding.
// ----------------------------------------------------------------------------
module mf3_pipe
    import mf3_pkg::*;
#(
    parameter int MAX_WIDTH  = MF3_MAX_WIDTH,
    parameter int PIXEL_BITS = MF3_PIXEL_BITS,
    localparam int COL_W     = $clog2(MAX_WIDTH)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  restart,
    input  logic                  accept,
    input  mf3_item_t             item,
    input  logic [PIXEL_BITS-1:0] px_in,
    input  logic [COL_W-1:0]      col_in,
    input  logic [COL_W-1:0]      rd_addr,
    input  logic [PIXEL_BITS-1:0] rd_upper,
    input  logic [PIXEL_BITS-1:0] rd_middle,
    input  logic                  out_ready,
    output logic                  stage_free,
    output logic                  stage_busy,
    output logic                  wr_en,
    output logic [COL_W-1:0]      wr_addr,
    output logic [PIXEL_BITS-1:0] wr_upper,
    output logic [PIXEL_BITS-1:0] wr_middle,
    output logic                  out_valid,
    output logic [PIX_W-1:0]      pixel_out,
    output logic                  frame_end
);

    // Work stage
    logic                       s1_valid_reg, s1_valid_next;
    mf3_item_t                  s1_item_reg;
    logic [PIXEL_BITS-1:0]      s1_px_reg;
    logic [COL_W-1:0]           s1_col_reg;
    logic                       fwd_reg, fwd_next;
    logic [PIXEL_BITS-1:0]      fwd_upper_reg;
    logic [PIXEL_BITS-1:0]      fwd_middle_reg;
    logic [5:0][PIXEL_BITS-1:0] win_reg, win_next;

    // Result register
    logic                       out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]           pixel_out_reg;
    logic                       frame_end_reg;

    logic [PIXEL_BITS-1:0]      top_pix;
    logic [PIXEL_BITS-1:0]      mid_pix;
    logic [PIXEL_BITS-1:0]      median_pix;
    logic [PIXEL_BITS-1:0]      result_pix;
    logic [8:0][PIXEL_BITS-1:0] taps;
    logic                       s1_move;
    logic                       out_load;

    // Line reads, with the value the stage wrote in the cycle of the read forwarded
    assign top_pix = fwd_reg ? fwd_upper_reg  : rd_upper;
    assign mid_pix = fwd_reg ? fwd_middle_reg : rd_middle;

    assign taps = {s1_px_reg, mid_pix, top_pix,
                   win_reg[5], win_reg[4], win_reg[3],
                   win_reg[2], win_reg[1], win_reg[0]};

    mf3_median9 #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_median (
        .taps   (taps),
        .median (median_pix)
    );

    // Result selection; the centre of the window is the pending output pixel
    always_comb
    begin
        if (s1_item_reg.flush)
            result_pix = s1_item_reg.full ? win_reg[4] : mid_pix;
        else if (s1_item_reg.interior)
            result_pix = median_pix;
        else
            result_pix = win_reg[4];
    end

    // Stage handshake
    assign s1_move    = s1_valid_reg &&
                        (!s1_item_reg.produce || !out_valid_reg || out_ready);
    assign stage_free = !s1_valid_reg || s1_move;
    assign stage_busy = s1_valid_reg;
    assign out_load   = s1_move && s1_item_reg.produce;

    // Line write-back for pixel transactions
    assign wr_en     = s1_move && !s1_item_reg.flush;
    assign wr_addr   = s1_col_reg;
    assign wr_upper  = mid_pix;
    assign wr_middle = s1_px_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_move)
            s1_valid_next = 1'b0;

        fwd_next = wr_en && (s1_col_reg == rd_addr);

        win_next = win_reg;
        if (restart)
            win_next = '0;
        else if (wr_en)
            win_next = {s1_px_reg, mid_pix, top_pix, win_reg[5], win_reg[4], win_reg[3]};

        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // Control registers and window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_reg       <= 1'b0;
            win_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            win_reg       <= win_next;
            out_valid_reg <= out_valid_next;
            if (accept)
                fwd_reg <= fwd_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg    <= item;
            s1_px_reg      <= px_in;
            s1_col_reg     <= col_in;
            fwd_upper_reg  <= mid_pix;
            fwd_middle_reg <= s1_px_reg;
        end
        if (out_load)
        begin
            pixel_out_reg <= PIX_W'(result_pix);
            frame_end_reg <= s1_item_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_out_reg;
    assign frame_end = frame_end_reg;

endmodule
